/* src/qs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qs_pkg
// Shared types, codes and constants of the quaternion slerp pipeline.
// ----------------------------------------------------------------------------
package qs_pkg;

	localparam int SQRT_STEPS   = 31;
	localparam int CORDIC_STEPS = 30;
	localparam int DIV_STEPS    = 32;
	// front 6, sqrt, vectoring, angle scale 1, rotation, divide, back 3
	localparam int LATENCY = 6 + SQRT_STEPS + CORDIC_STEPS + 1 + CORDIC_STEPS + DIV_STEPS + 3;

	localparam int PADDR_W = 3;
	localparam logic [0:0]  IDX_THR   = 1'b0;
	localparam logic [14:0] THR_RESET = 15'd3;

	localparam logic [16:0] ONE_Q16     = 17'd65536;
	localparam logic [33:0] CORDIC_GAIN = 34'd652032874;

	// atan(2^-i) in Q2.30
	localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
		30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
		30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
		30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
		30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
		30'd32,        30'd16,        30'd8,         30'd4,         30'd2
	};

	typedef enum logic [1:0] {
		PATH_EQUAL     = 2'd0,
		PATH_LINEAR    = 2'd1,
		PATH_SPHERICAL = 2'd2
	} path_t;

	typedef struct packed {
		logic signed [15:0] first_x;
		logic signed [15:0] first_y;
		logic signed [15:0] first_z;
		logic signed [15:0] first_w;
		logic signed [15:0] second_x;
		logic signed [15:0] second_y;
		logic signed [15:0] second_z;
		logic signed [15:0] second_w;
		logic        [16:0] blend;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic signed [15:0] out_z;
		logic signed [15:0] out_w;
		logic        [1:0]  path_taken;
	} out_item_t;

	// operands that ride along with the math: q0, short-path q1, weights, path
	typedef struct packed {
		logic [3:0][15:0] a;
		logic [3:0][16:0] b;
		logic [16:0]      w0;
		logic [16:0]      w1;
		path_t            path;
	} side_t;

endpackage
`default_nettype wire

/* src/quaternion_slerp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_slerp
// Shortest-path spherical interpolation of two Q1.15 quaternions, fully
// pipelined: dot/path front end, sqrt, vectoring CORDIC, sine CORDIC,
// coefficient divide, weighted sum with rounding and saturation.
//
//   channel  | signals                               | direction
//   ---------+---------------------------------------+----------
//   command  | start, item (busy is out)             | in
//   result   | done, result                          | out
//   config   | psel penable pwrite paddr pwdata      | in
//            | prdata pready                         | out
//
// One transaction per clock; the pipeline length is dominated by the bit-per-stage
// sqrt (31), the two 30-step CORDICs and the 32-step divide.
// busy is never raised: the pipeline has no stall and the receiver takes
// done/result in the cycle they appear. Reset clears all valid bits and sets
// linear_threshold to 3.
// ----------------------------------------------------------------------------
module quaternion_slerp import qs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  in_item_t           item,
	output logic               done,
	output out_item_t          result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam logic [33:0] DOT_ONE    = 34'd1 << 30;
	localparam logic [60:0] RAD_ONE    = 61'd1 << 60;
	localparam logic [32:0] COEF_ONE   = 33'd1 << 30;
	localparam logic [50:0] ROUND_HALF = 51'd1 << 29;

	function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
		if (v > 21'sd32767) begin
			return 16'sh7fff;
		end else if (v < -21'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	// ---------------- configuration ----------------
	logic [14:0] thr_q;

	assign pready = 1'b1;
	assign busy   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && pready && paddr[PADDR_W-1] == IDX_THR) begin
			thr_q <= pwdata[14:0];
		end
	end

	always_comb begin
		case (paddr[PADDR_W-1])
			IDX_THR: prdata = {17'b0, thr_q};
			default: prdata = '0;
		endcase
	end

	// ---------------- s1: capture ----------------
	logic     valid_s1;
	in_item_t in_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		in_s1 <= item;
	end

	// ---------------- s2: products ----------------
	logic [3:0][15:0]   a_c, b_c;
	logic [16:0]        t_c;
	logic               valid_s2, same_s2;
	logic [3:0][15:0]   a_s2, b_s2;
	logic [16:0]        t_s2;
	logic signed [31:0] prod_s2 [4];

	assign a_c = {in_s1.first_w, in_s1.first_z, in_s1.first_y, in_s1.first_x};
	assign b_c = {in_s1.second_w, in_s1.second_z, in_s1.second_y, in_s1.second_x};
	assign t_c = (in_s1.blend > ONE_Q16) ? ONE_Q16 : in_s1.blend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		same_s2 <= (a_c == b_c);
		a_s2    <= a_c;
		b_s2    <= b_c;
		t_s2    <= t_c;
		for (int i = 0; i < 4; i++) begin
			prod_s2[i] <= $signed(a_c[i]) * $signed(b_c[i]);
		end
	end

	// ---------------- s3: dot ----------------
	logic signed [33:0] dot_c;
	logic               valid_s3, same_s3;
	logic [3:0][15:0]   a_s3, b_s3;
	logic [16:0]        t_s3;
	logic signed [33:0] dot_s3;

	assign dot_c = 34'(prod_s2[0]) + 34'(prod_s2[1]) + 34'(prod_s2[2]) + 34'(prod_s2[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		same_s3 <= same_s2;
		a_s3    <= a_s2;
		b_s3    <= b_s2;
		t_s3    <= t_s2;
		dot_s3  <= dot_c;
	end

	// ---------------- s4: short path, path select ----------------
	logic               neg_c;
	logic signed [33:0] dabs_c;
	logic [33:0]        lim_c;
	side_t              side_c;
	logic               valid_s4;
	side_t              side_s4;
	logic [32:0]        dot_s4;

	assign neg_c  = dot_s3[33];
	assign dabs_c = neg_c ? -dot_s3 : dot_s3;
	// linear when 1 - dot <= thr, i.e. dot >= 1 - thr
	assign lim_c  = DOT_ONE - {4'b0, thr_q, 15'b0};

	always_comb begin
		side_c.a  = a_s3;
		side_c.w0 = ONE_Q16 - t_s3;
		side_c.w1 = t_s3;
		for (int i = 0; i < 4; i++) begin
			side_c.b[i] = neg_c ? -{b_s3[i][15], b_s3[i]} : {b_s3[i][15], b_s3[i]};
		end
		if (same_s3) begin
			side_c.path = PATH_EQUAL;
		end else if (dabs_c >= $signed(lim_c)) begin
			side_c.path = PATH_LINEAR;
		end else begin
			side_c.path = PATH_SPHERICAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s4 <= side_c;
		dot_s4  <= dabs_c[32:0];
	end

	// ---------------- s5: dot squared ----------------
	logic        valid_s5;
	side_t       side_s5;
	logic [29:0] dot_s5;
	logic [59:0] sq_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		side_s5 <= side_s4;
		dot_s5  <= dot_s4[29:0];
		sq_s5   <= dot_s4[29:0] * dot_s4[29:0];
	end

	// ---------------- s6: 1 - dot^2 ----------------
	logic        valid_s6;
	side_t       side_s6;
	logic [29:0] dot_s6;
	logic [60:0] rad_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		side_s6 <= side_s5;
		dot_s6  <= dot_s5;
		rad_s6  <= RAD_ONE - {1'b0, sq_s5};
	end

	// ---------------- sin(theta) and theta ----------------
	logic               sq_valid;
	side_t              sq_side;
	logic [29:0]        sq_dot;
	logic [30:0]        sq_root;

	qs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s6),
		.in_side  (side_s6),
		.in_rad   (rad_s6),
		.in_dot   (dot_s6),
		.out_valid(sq_valid),
		.out_side (sq_side),
		.out_dot  (sq_dot),
		.out_root (sq_root)
	);

	logic               vc_valid;
	side_t              vc_side;
	logic [30:0]        vc_root;
	logic signed [33:0] vc_theta;

	qs_vec u_vec (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sq_valid),
		.in_side  (sq_side),
		.in_dot   (sq_dot),
		.in_root  (sq_root),
		.out_valid(vc_valid),
		.out_side (vc_side),
		.out_root (vc_root),
		.out_theta(vc_theta)
	);

	// ---------------- s7: scaled angles ----------------
	logic signed [51:0] m0_c, m1_c;
	logic               valid_s7;
	side_t              side_s7;
	logic [30:0]        root_s7;
	logic signed [33:0] ang_s7 [2];

	assign m0_c = vc_theta * $signed({1'b0, vc_side.w0});
	assign m1_c = vc_theta * $signed({1'b0, vc_side.w1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else begin
			valid_s7 <= vc_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_s7   <= vc_side;
		root_s7   <= vc_root;
		ang_s7[0] <= m0_c[49:16];
		ang_s7[1] <= m1_c[49:16];
	end

	// ---------------- sines and coefficients ----------------
	logic               rt_valid;
	side_t              rt_side;
	logic [30:0]        rt_root;
	logic signed [33:0] rt_sin [2];

	qs_rot u_rot (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s7),
		.in_side  (side_s7),
		.in_root  (root_s7),
		.in_ang   (ang_s7),
		.out_valid(rt_valid),
		.out_side (rt_side),
		.out_root (rt_root),
		.out_sin  (rt_sin)
	);

	logic        dv_valid;
	side_t       dv_side;
	logic [31:0] dv_quo [2];
	logic        dv_neg [2];

	qs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rt_valid),
		.in_side  (rt_side),
		.in_root  (rt_root),
		.in_sin   (rt_sin),
		.out_valid(dv_valid),
		.out_side (dv_side),
		.out_quo  (dv_quo),
		.out_neg  (dv_neg)
	);

	// ---------------- s8: coefficient select ----------------
	// equal and linear paths skip the divider: linear uses weights << 14 (Q2.30), equal uses 1.0 and 0
	logic signed [32:0] c0_c, c1_c;
	logic               valid_s8;
	side_t              side_s8;
	logic signed [32:0] c0_s8, c1_s8;

	always_comb begin
		case (dv_side.path)
			PATH_SPHERICAL: begin
				c0_c = dv_neg[0] ? -$signed({1'b0, dv_quo[0]}) : $signed({1'b0, dv_quo[0]});
				c1_c = dv_neg[1] ? -$signed({1'b0, dv_quo[1]}) : $signed({1'b0, dv_quo[1]});
			end
			PATH_LINEAR: begin
				c0_c = $signed({2'b0, dv_side.w0, 14'b0});
				c1_c = $signed({2'b0, dv_side.w1, 14'b0});
			end
			default: begin
				c0_c = $signed(COEF_ONE);
				c1_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else begin
			valid_s8 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_s8 <= dv_side;
		c0_s8   <= c0_c;
		c1_s8   <= c1_c;
	end

	// ---------------- s9: weighted terms ----------------
	logic               valid_s9;
	path_t              path_s9;
	logic signed [48:0] ta_s9 [4];
	logic signed [49:0] tb_s9 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
		end else begin
			valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		path_s9 <= side_s8.path;
		for (int i = 0; i < 4; i++) begin
			ta_s9[i] <= $signed(side_s8.a[i]) * c0_s8;
			tb_s9[i] <= $signed(side_s8.b[i]) * c1_s8;
		end
	end

	// ---------------- s10: sum, round, saturate ----------------
	logic signed [50:0] sum_c [4];
	logic signed [15:0] r_c   [4];
	logic               valid_s10;
	out_item_t          out_s10;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sum_c[i] = 51'(ta_s9[i]) + 51'(tb_s9[i]) + $signed(ROUND_HALF);
			r_c[i]   = sat16(sum_c[i][50:30]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
		end else begin
			valid_s10 <= valid_s9;
		end
	end

	always_ff @(posedge clk) begin
		out_s10.out_x      <= r_c[0];
		out_s10.out_y      <= r_c[1];
		out_s10.out_z      <= r_c[2];
		out_s10.out_w      <= r_c[3];
		out_s10.path_taken <= path_s9;
	end

	assign done   = valid_s10;
	assign result = out_s10;

endmodule
`default_nettype wire

/* src/qs_sqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qs_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qs_sqrt import qs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  side_t       in_side,
	input  logic [60:0] in_rad,
	input  logic [29:0] in_dot,
	output logic        out_valid,
	output side_t       out_side,
	output logic [29:0] out_dot,
	output logic [30:0] out_root
);

	logic        vld_s  [SQRT_STEPS];
	side_t       side_s [SQRT_STEPS];
	logic [60:0] rad_s  [SQRT_STEPS];
	logic [61:0] acc_s  [SQRT_STEPS];
	logic [29:0] dot_s  [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [62:0] BIT = 63'd1 << (2 * (SQRT_STEPS - 1 - k));
		logic        vld_in;
		side_t       side_in;
		logic [60:0] rad_in;
		logic [61:0] acc_in;
		logic [29:0] dot_in;
		logic [62:0] trial;
		logic        take;

		if (k == 0) begin : g_head
			assign vld_in  = in_valid;
			assign side_in = in_side;
			assign rad_in  = in_rad;
			assign acc_in  = '0;
			assign dot_in  = in_dot;
		end else begin : g_body
			assign vld_in  = vld_s[k-1];
			assign side_in = side_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign acc_in  = acc_s[k-1];
			assign dot_in  = dot_s[k-1];
		end

		assign trial = {1'b0, acc_in} + BIT;
		assign take  = {2'b0, rad_in} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			side_s[k] <= side_in;
			dot_s[k]  <= dot_in;
			if (take) begin
				rad_s[k] <= rad_in - trial[60:0];
				acc_s[k] <= 62'(({1'b0, acc_in} >> 1) + BIT);
			end else begin
				rad_s[k] <= rad_in;
				acc_s[k] <= acc_in >> 1;
			end
		end
	end

	assign out_valid = vld_s[SQRT_STEPS-1];
	assign out_side  = side_s[SQRT_STEPS-1];
	assign out_dot   = dot_s[SQRT_STEPS-1];
	assign out_root  = acc_s[SQRT_STEPS-1][30:0];

endmodule
`default_nettype wire

/* src/qs_vec.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qs_vec
// Vectoring CORDIC, one micro-rotation per stage: angle of (dot, sin).
// ----------------------------------------------------------------------------
module qs_vec import qs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  side_t              in_side,
	input  logic [29:0]        in_dot,
	input  logic [30:0]        in_root,
	output logic               out_valid,
	output side_t              out_side,
	output logic [30:0]        out_root,
	output logic signed [33:0] out_theta
);

	logic               vld_s  [CORDIC_STEPS];
	side_t              side_s [CORDIC_STEPS];
	logic [30:0]        root_s [CORDIC_STEPS];
	logic signed [33:0] x_s    [CORDIC_STEPS];
	logic signed [33:0] y_s    [CORDIC_STEPS];
	logic signed [33:0] z_s    [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic               vld_in;
		side_t              side_in;
		logic [30:0]        root_in;
		logic signed [33:0] x_in;
		logic signed [33:0] y_in;
		logic signed [33:0] z_in;
		logic signed [33:0] atan;

		if (i == 0) begin : g_head
			assign vld_in  = in_valid;
			assign side_in = in_side;
			assign root_in = in_root;
			assign x_in    = $signed({4'b0, in_dot});
			assign y_in    = $signed({3'b0, in_root});
			assign z_in    = '0;
		end else begin : g_body
			assign vld_in  = vld_s[i-1];
			assign side_in = side_s[i-1];
			assign root_in = root_s[i-1];
			assign x_in    = x_s[i-1];
			assign y_in    = y_s[i-1];
			assign z_in    = z_s[i-1];
		end

		assign atan = $signed({4'b0, ATAN_TAB[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			side_s[i] <= side_in;
			root_s[i] <= root_in;
			if (y_in > 0) begin
				x_s[i] <= x_in + (y_in >>> i);
				y_s[i] <= y_in - (x_in >>> i);
				z_s[i] <= z_in + atan;
			end else begin
				x_s[i] <= x_in - (y_in >>> i);
				y_s[i] <= y_in + (x_in >>> i);
				z_s[i] <= z_in - atan;
			end
		end
	end

	assign out_valid = vld_s[CORDIC_STEPS-1];
	assign out_side  = side_s[CORDIC_STEPS-1];
	assign out_root  = root_s[CORDIC_STEPS-1];
	assign out_theta = z_s[CORDIC_STEPS-1];

endmodule
`default_nettype wire

/* src/qs_rot.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qs_rot
// Two-lane rotation CORDIC, one micro-rotation per stage; yields sin of each
// lane's angle in Q2.30.
// ----------------------------------------------------------------------------
module qs_rot import qs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  side_t              in_side,
	input  logic [30:0]        in_root,
	input  logic signed [33:0] in_ang [2],
	output logic               out_valid,
	output side_t              out_side,
	output logic [30:0]        out_root,
	output logic signed [33:0] out_sin [2]
);

	logic               vld_s  [CORDIC_STEPS];
	side_t              side_s [CORDIC_STEPS];
	logic [30:0]        root_s [CORDIC_STEPS];
	logic signed [33:0] x_s    [CORDIC_STEPS][2];
	logic signed [33:0] y_s    [CORDIC_STEPS][2];
	logic signed [33:0] z_s    [CORDIC_STEPS][2];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic               vld_in;
		side_t              side_in;
		logic [30:0]        root_in;
		logic signed [33:0] atan;

		if (i == 0) begin : g_head
			assign vld_in  = in_valid;
			assign side_in = in_side;
			assign root_in = in_root;
		end else begin : g_body
			assign vld_in  = vld_s[i-1];
			assign side_in = side_s[i-1];
			assign root_in = root_s[i-1];
		end

		assign atan = $signed({4'b0, ATAN_TAB[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			side_s[i] <= side_in;
			root_s[i] <= root_in;
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic signed [33:0] x_in;
			logic signed [33:0] y_in;
			logic signed [33:0] z_in;

			if (i == 0) begin : g_head
				assign x_in = $signed(CORDIC_GAIN);
				assign y_in = '0;
				assign z_in = in_ang[l];
			end else begin : g_body
				assign x_in = x_s[i-1][l];
				assign y_in = y_s[i-1][l];
				assign z_in = z_s[i-1][l];
			end

			always_ff @(posedge clk) begin
				if (z_in >= 0) begin
					x_s[i][l] <= x_in - (y_in >>> i);
					y_s[i][l] <= y_in + (x_in >>> i);
					z_s[i][l] <= z_in - atan;
				end else begin
					x_s[i][l] <= x_in + (y_in >>> i);
					y_s[i][l] <= y_in - (x_in >>> i);
					z_s[i][l] <= z_in + atan;
				end
			end
		end
	end

	assign out_valid  = vld_s[CORDIC_STEPS-1];
	assign out_side   = side_s[CORDIC_STEPS-1];
	assign out_root   = root_s[CORDIC_STEPS-1];
	assign out_sin[0] = y_s[CORDIC_STEPS-1][0];
	assign out_sin[1] = y_s[CORDIC_STEPS-1][1];

endmodule
`default_nettype wire

/* src/qs_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qs_div
// Two-lane restoring divider, one quotient bit per stage:
// q = trunc(sin * 2^30 / root), returned as magnitude and sign.
// ----------------------------------------------------------------------------
module qs_div import qs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  side_t              in_side,
	input  logic [30:0]        in_root,
	input  logic signed [33:0] in_sin [2],
	output logic               out_valid,
	output side_t              out_side,
	output logic [31:0]        out_quo [2],
	output logic               out_neg [2]
);

	logic        vld_s  [DIV_STEPS];
	side_t       side_s [DIV_STEPS];
	logic [30:0] root_s [DIV_STEPS];
	logic [31:0] rem_s  [DIV_STEPS][2];
	logic [31:0] num_s  [DIV_STEPS][2];
	logic [31:0] quo_s  [DIV_STEPS][2];
	logic        neg_s  [DIV_STEPS][2];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic        vld_in;
		side_t       side_in;
		logic [30:0] root_in;

		if (k == 0) begin : g_head
			assign vld_in  = in_valid;
			assign side_in = in_side;
			assign root_in = in_root;
		end else begin : g_body
			assign vld_in  = vld_s[k-1];
			assign side_in = side_s[k-1];
			assign root_in = root_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			side_s[k] <= side_in;
			root_s[k] <= root_in;
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [31:0] rem_in;
			logic [31:0] num_in;
			logic [31:0] quo_in;
			logic        neg_in;
			logic [31:0] rem_sh;
			logic        take;

			if (k == 0) begin : g_head
				logic signed [33:0] mag;
				assign mag    = in_sin[l][33] ? -in_sin[l] : in_sin[l];
				// top quotient bits are known zero: start with |sin| >> 2 as remainder
				assign rem_in = mag[33:2];
				assign num_in = {mag[1:0], 30'b0};
				assign quo_in = '0;
				assign neg_in = in_sin[l][33];
			end else begin : g_body
				assign rem_in = rem_s[k-1][l];
				assign num_in = num_s[k-1][l];
				assign quo_in = quo_s[k-1][l];
				assign neg_in = neg_s[k-1][l];
			end

			assign rem_sh = {rem_in[30:0], num_in[31]};
			assign take   = rem_sh >= {1'b0, root_in};

			always_ff @(posedge clk) begin
				rem_s[k][l] <= take ? rem_sh - {1'b0, root_in} : rem_sh;
				num_s[k][l] <= num_in << 1;
				quo_s[k][l] <= {quo_in[30:0], take};
				neg_s[k][l] <= neg_in;
			end
		end
	end

	assign out_valid  = vld_s[DIV_STEPS-1];
	assign out_side   = side_s[DIV_STEPS-1];
	assign out_quo[0] = quo_s[DIV_STEPS-1][0];
	assign out_quo[1] = quo_s[DIV_STEPS-1][1];
	assign out_neg[0] = neg_s[DIV_STEPS-1][0];
	assign out_neg[1] = neg_s[DIV_STEPS-1][1];

endmodule
`default_nettype wire

/* src/qs_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qs_checker
// Port-level checks of the slerp pipeline: fixed latency and equal path.
// ----------------------------------------------------------------------------
module qs_checker import qs_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input in_item_t           item,
	input logic               done,
	input out_item_t          result,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [31:0]        pwdata,
	input logic [31:0]        prdata,
	input logic               pready
);

	logic in_same;
	logic accept;

	assign accept  = start && !busy;
	assign in_same = item.first_x == item.second_x && item.first_y == item.second_y &&
		item.first_z == item.second_z && item.first_w == item.second_w;

	// every accepted transaction produces a done
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("result missing after accepted transaction");

	a_latency_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without matching transaction");

	a_equal_sel: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((result.path_taken == PATH_EQUAL) == $past(in_same, LATENCY)))
		else $error("equal-input path mismatch");

	a_equal_val: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.path_taken == PATH_EQUAL |->
			result.out_x == $past(item.first_x, LATENCY) &&
			result.out_y == $past(item.first_y, LATENCY) &&
			result.out_z == $past(item.first_z, LATENCY) &&
			result.out_w == $past(item.first_w, LATENCY))
		else $error("equal path did not return first quaternion");

endmodule

bind quaternion_slerp qs_checker u_qs_checker (.*);
`default_nettype wire
